// ===== design/spf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_pkg: shared types for the scanline polygon span fill block
// Request codes, table widths and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int PIX_W  = 9;
	localparam int LEFT_W = 10;

	localparam logic [LEFT_W-1:0] EMPTY_LEFT  = 10'd512;
	localparam logic [PIX_W-1:0]  EMPTY_RIGHT = 9'd0;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_SPAN  = 2'd2
	} req_t;

	typedef struct packed {
		logic load;        // capture request fields
		logic clr_step;    // write one empty entry, advance sweep
		logic div_start;   // launch slope division
		logic walk_init;   // set up slope, running x and row
		logic walk_step;   // read one row, advance running x
		logic span_read;   // read the queried row
		logic resp;        // drive the result beat
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic walk_last;
	} status_t;

endpackage

// ===== design/scanline_polygon_span_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill: polygon edge table with per-row spans
// Keeps left/right extents for every row; clears, adds edges with a
// fixed-point slope walk, and reads back the span of one row.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start & !busy          req_type, edge_x_a/y_a, edge_x_b/y_b, query_row
//  result    result_valid (1 cyc)   span_valid, span_left, span_right_excl, req_done
//
//  Clear: one table entry written per cycle.
//  Add edge: the divider makes one slope bit per cycle, then one table row per cycle.
//  Span read: the result comes from the registered memory read.
//  After reset the table is swept empty, with busy high.
//  One request at a time; the result beat cannot be held off.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill #(
	parameter int ROWS      = 512,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [spf_pkg::PIX_W-1:0]   edge_x_a,
	input  logic [spf_pkg::PIX_W-1:0]   edge_y_a,
	input  logic [spf_pkg::PIX_W-1:0]   edge_x_b,
	input  logic [spf_pkg::PIX_W-1:0]   edge_y_b,
	input  logic [spf_pkg::PIX_W-1:0]   query_row,
	output logic                        result_valid,
	output logic                        span_valid,
	output logic [spf_pkg::LEFT_W-1:0]  span_left,
	output logic [spf_pkg::PIX_W-1:0]   span_right_excl,
	output logic                        req_done
);

	spf_pkg::cmd_t    cmd;
	spf_pkg::status_t st;

	spf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	spf_dp #(
		.ROWS      (ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.req_type        (req_type),
		.edge_x_a        (edge_x_a),
		.edge_y_a        (edge_y_a),
		.edge_x_b        (edge_x_b),
		.edge_y_b        (edge_y_b),
		.query_row       (query_row),
		.result_valid    (result_valid),
		.span_valid      (span_valid),
		.span_left       (span_left),
		.span_right_excl (span_right_excl),
		.req_done        (req_done)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beat longer than one cycle");

	a_idle_at_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result beat while still busy");

	a_span_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && span_valid) |-> req_done)
		else $error("filled span reported without completion");
`endif

endmodule

// ===== design/spf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_div: radix-2 restoring divider
// One quotient bit per cycle; a zero divisor returns the dividend unchanged.
// ----------------------------------------------------------------------------
module spf_div #(
	parameter int NW = 25,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (divisor == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= CW'(NW);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== design/spf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_dp: span fill datapath
// Extent table memory, clear sweep, slope divider, row walk with a one-stage
// read-modify-write pipeline, and the result registers.
// ----------------------------------------------------------------------------
module spf_dp #(
	parameter int ROWS      = 512,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spf_pkg::cmd_t               cmd,
	output spf_pkg::status_t            st,
	input  logic [1:0]                  req_type,
	input  logic [spf_pkg::PIX_W-1:0]   edge_x_a,
	input  logic [spf_pkg::PIX_W-1:0]   edge_y_a,
	input  logic [spf_pkg::PIX_W-1:0]   edge_x_b,
	input  logic [spf_pkg::PIX_W-1:0]   edge_y_b,
	input  logic [spf_pkg::PIX_W-1:0]   query_row,
	output logic                        result_valid,
	output logic                        span_valid,
	output logic [spf_pkg::LEFT_W-1:0]  span_left,
	output logic [spf_pkg::PIX_W-1:0]   span_right_excl,
	output logic                        req_done
);

	localparam int PW = spf_pkg::PIX_W;
	localparam int LW = spf_pkg::LEFT_W;
	localparam int EW = LW + PW;
	localparam int AW = $clog2(ROWS);
	localparam int NW = PW + FRAC_BITS;
	localparam int XW = FRAC_BITS + PW + 2;

	// request capture
	logic [1:0]    req_q;
	logic [PW-1:0] xlo_q, ylo_q, yhi_q, adx_q, dy_q, qrow_q;
	logic          dx_neg_q, qoob_q;

	logic          swap;
	logic [PW-1:0] xlo_n, xhi_n, ylo_n, yhi_n;

	assign swap  = edge_y_b < edge_y_a;
	assign xlo_n = swap ? edge_x_b : edge_x_a;
	assign xhi_n = swap ? edge_x_a : edge_x_b;
	assign ylo_n = swap ? edge_y_b : edge_y_a;
	assign yhi_n = swap ? edge_y_a : edge_y_b;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			xlo_q    <= xlo_n;
			ylo_q    <= ylo_n;
			yhi_q    <= yhi_n;
			dy_q     <= yhi_n - ylo_n;
			dx_neg_q <= xhi_n < xlo_n;
			adx_q    <= (xhi_n < xlo_n) ? xlo_n - xhi_n : xhi_n - xlo_n;
			qrow_q   <= query_row;
			qoob_q   <= !(32'(query_row) < ROWS);
		end
	end

	// slope division
	logic          div_done;
	logic [NW-1:0] quot;

	spf_div #(
		.NW (NW),
		.DW (PW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (NW'(adx_q) << FRAC_BITS),
		.divisor  (dy_q),
		.done     (div_done),
		.quot     (quot)
	);

	// walk registers
	logic signed [XW-1:0] slope_q, xf_q, xf_s1, slope_mag;
	logic [PW-1:0]        row_q;
	logic [AW-1:0]        row_s1;
	logic                 upd_s1;

	assign slope_mag = XW'(quot);

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			slope_q <= dx_neg_q ? -slope_mag : slope_mag;
			xf_q    <= XW'(xlo_q) << FRAC_BITS;
			row_q   <= ylo_q;
		end else if (cmd.walk_step) begin
			xf_q  <= xf_q + slope_q;
			row_q <= row_q + PW'(1);
		end
		if (cmd.walk_step) begin
			xf_s1  <= xf_q;
			row_s1 <= AW'(row_q);
		end
	end

	// clear sweep counter; reset value starts the power-up pass
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			upd_s1    <= 1'b0;
		end else begin
			upd_s1 <= cmd.walk_step && (32'(row_q) < ROWS);
			if (cmd.load)
				clr_cnt_q <= '0;
			else if (cmd.clr_step)
				clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// extent memory: {left, right}
	logic [EW-1:0] mem [ROWS];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en, rd_en;

	logic [LW-1:0] rd_left;
	logic [PW-1:0] rd_right;
	logic [PW-1:0] xi;
	logic          frac_nz, go_left, go_right;

	assign rd_left  = rd_q[EW-1:PW];
	assign rd_right = rd_q[PW-1:0];
	// running x is never negative on a walked row and stays below 512
	assign xi       = xf_s1[FRAC_BITS+PW-1:FRAC_BITS];
	assign frac_nz  = |xf_s1[FRAC_BITS-1:0];
	assign go_left  = {1'b0, xi} < rd_left;
	assign go_right = (xi > rd_right) || ((xi == rd_right) && frac_nz);

	assign rd_en   = cmd.walk_step || cmd.span_read;
	assign rd_addr = cmd.span_read ? AW'(qrow_q) : AW'(row_q);

	always_comb begin
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = {spf_pkg::EMPTY_LEFT, spf_pkg::EMPTY_RIGHT};
		end else begin
			wr_en   = upd_s1;
			wr_addr = row_s1;
			wr_data = {go_left ? {1'b0, xi} : rd_left, go_right ? xi : rd_right};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// result registers
	logic [LW-1:0] q_left;
	logic [PW-1:0] q_right;

	assign q_left  = qoob_q ? spf_pkg::EMPTY_LEFT : rd_left;
	assign q_right = qoob_q ? spf_pkg::EMPTY_RIGHT : rd_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= cmd.resp;
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			unique case (req_q)
				spf_pkg::REQ_CLEAR, spf_pkg::REQ_ADD: begin
					span_valid      <= 1'b0;
					span_left       <= '0;
					span_right_excl <= '0;
					req_done        <= 1'b1;
				end
				spf_pkg::REQ_SPAN: begin
					span_valid      <= q_left <= {1'b0, q_right};
					span_left       <= q_left;
					span_right_excl <= q_right;
					req_done        <= 1'b1;
				end
				default: begin
					span_valid      <= 1'b0;
					span_left       <= '0;
					span_right_excl <= '0;
					req_done        <= 1'b0;
				end
			endcase
		end
	end

	assign st.clr_last  = clr_cnt_q == AW'(ROWS - 1);
	assign st.div_done  = div_done;
	assign st.walk_last = row_q == yhi_q;

endmodule

// ===== design/spf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spf_ctrl: span fill controller
// Sequences the power-up clear, clear, add-edge and span requests; a reserved code goes straight to the result beat.
// ----------------------------------------------------------------------------
module spf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       req_type,
	input  spf_pkg::status_t st,
	output spf_pkg::cmd_t    cmd,
	output logic             busy
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_WALK,
		ST_SPAN,
		ST_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			unique case (state_q)
				ST_INIT:
					if (st.clr_last)
						state_q <= ST_IDLE;
				ST_IDLE:
					if (start) begin
						unique case (spf_pkg::req_t'(req_type))
							spf_pkg::REQ_CLEAR: state_q <= ST_CLEAR;
							spf_pkg::REQ_ADD:   state_q <= ST_DIV_GO;
							spf_pkg::REQ_SPAN:  state_q <= ST_SPAN;
							default:            state_q <= ST_RESP;
						endcase
					end
				ST_CLEAR:
					if (st.clr_last)
						state_q <= ST_RESP;
				ST_DIV_GO:
					state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT:
					if (st.div_done)
						state_q <= ST_WALK;
				ST_WALK:
					if (st.walk_last)
						state_q <= ST_RESP;
				ST_SPAN:
					state_q <= ST_RESP;
				ST_RESP:
					state_q <= ST_IDLE;
				default:
					state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && start;
		cmd.clr_step  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		cmd.div_start = state_q == ST_DIV_GO;
		cmd.walk_init = (state_q == ST_DIV_WAIT) && st.div_done;
		cmd.walk_step = state_q == ST_WALK;
		cmd.span_read = state_q == ST_SPAN;
		cmd.resp      = state_q == ST_RESP;
	end

	assign busy = state_q != ST_IDLE;

endmodule

// ===== tb/sv/scanline_polygon_span_fill_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill_tb: self-checking bench for the span fill block
// Drives clear, add-edge, span and reserved requests through the start/busy
// handshake. A table of directed requests runs first, then random clears,
// polygons, span reads mostly of their rows, and loose noise. Each result beat
// is compared with a typed-in answer or with a software copy of the per-row extent tables.
// ----------------------------------------------------------------------------
module scanline_polygon_span_fill_tb;

	localparam int ROWS       = 512;
	localparam int FRAC       = 16;
	localparam int RAND_ITEMS = 1000;
	localparam int DRAIN_CYC  = 600;
	localparam longint LIMIT_CYC = 4_000_000;
	localparam logic [1:0] REQ_RSVD = 2'd3;

	typedef struct packed {
		logic [1:0]                kind;
		logic [spf_pkg::PIX_W-1:0] xa;
		logic [spf_pkg::PIX_W-1:0] ya;
		logic [spf_pkg::PIX_W-1:0] xb;
		logic [spf_pkg::PIX_W-1:0] yb;
		logic [spf_pkg::PIX_W-1:0] row;
	} edge_req_t;

	typedef struct packed {
		logic                       valid;
		logic [spf_pkg::LEFT_W-1:0] left_x;
		logic [spf_pkg::PIX_W-1:0]  right_x;
		logic                       done;
	} span_res_t;

	typedef struct packed {
		edge_req_t rq;
		logic      fixed;
		span_res_t want;
	} dir_row_t;

	localparam int N_DIR = 24;
	localparam span_res_t EMPTY_ROW = '{1'b0, spf_pkg::EMPTY_LEFT, spf_pkg::EMPTY_RIGHT, 1'b1};
	localparam span_res_t ACK       = '{1'b0, 10'd0, 9'd0, 1'b1};
	localparam span_res_t NO_ACK    = '{1'b0, 10'd0, 9'd0, 1'b0};

	// fixed rows carry a typed-in answer; the rest go through the predictor
	dir_row_t dir_tab [N_DIR] = '{
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},   1'b1, EMPTY_ROW},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd511}, 1'b1, EMPTY_ROW},
		'{'{REQ_RSVD,           9'd511, 9'd511, 9'd511, 9'd511, 9'd511}, 1'b1, NO_ACK},
		'{'{spf_pkg::REQ_CLEAR, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_ADD,   9'd0,   9'd0,   9'd511, 9'd511, 9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},   1'b0, NO_ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd511}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd256}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_ADD,   9'd511, 9'd100, 9'd0,   9'd100, 9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd100}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_ADD,   9'd300, 9'd400, 9'd300, 9'd10,  9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd10},  1'b0, NO_ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd400}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_ADD,   9'd500, 9'd20,  9'd5,   9'd300, 9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd20},  1'b0, NO_ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd300}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd150}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_ADD,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_ADD,   9'd511, 9'd511, 9'd511, 9'd511, 9'd0},   1'b1, ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd511}, 1'b0, NO_ACK},
		'{'{spf_pkg::REQ_CLEAR, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511}, 1'b1, ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd100}, 1'b1, EMPTY_ROW},
		'{'{REQ_RSVD,           9'd0,   9'd0,   9'd0,   9'd0,   9'd0},   1'b1, NO_ACK},
		'{'{spf_pkg::REQ_SPAN,  9'd0,   9'd0,   9'd0,   9'd0,   9'd0},   1'b1, EMPTY_ROW}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [1:0]                 req_type;
	logic [spf_pkg::PIX_W-1:0]  edge_x_a;
	logic [spf_pkg::PIX_W-1:0]  edge_y_a;
	logic [spf_pkg::PIX_W-1:0]  edge_x_b;
	logic [spf_pkg::PIX_W-1:0]  edge_y_b;
	logic [spf_pkg::PIX_W-1:0]  query_row;
	logic                       result_valid;
	logic                       span_valid;
	logic [spf_pkg::LEFT_W-1:0] span_left;
	logic [spf_pkg::PIX_W-1:0]  span_right_excl;
	logic                       req_done;

	scanline_polygon_span_fill #(
		.ROWS      (ROWS),
		.FRAC_BITS (FRAC)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.edge_x_a        (edge_x_a),
		.edge_y_a        (edge_y_a),
		.edge_x_b        (edge_x_b),
		.edge_y_b        (edge_y_b),
		.query_row       (query_row),
		.result_valid    (result_valid),
		.span_valid      (span_valid),
		.span_left       (span_left),
		.span_right_excl (span_right_excl),
		.req_done        (req_done)
	);

	// software copy of the per-row extents
	logic [spf_pkg::LEFT_W-1:0] left_ext  [ROWS];
	logic [spf_pkg::PIX_W-1:0]  right_ext [ROWS];

	span_res_t pending_spans [$];
	int  fail_cnt;
	int  n_items, n_clear, n_add, n_span, n_rsvd, n_filled, n_results;
	bit  no_idle;
	longint cyc = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [spf_pkg::PIX_W-1:0] pixel_of(longint xf);
		longint xi;
		if (xf < 0)
			return '0;
		xi = xf >>> FRAC;
		if (xi > 511)
			xi = 511;
		return spf_pkg::PIX_W'(xi);
	endfunction

	function automatic void trace_edge(edge_req_t rq);
		longint xlo, ylo, xhi, yhi, slope, xf;
		int y;
		xlo = rq.xa; ylo = rq.ya; xhi = rq.xb; yhi = rq.yb;
		if (rq.yb < rq.ya) begin
			xlo = rq.xb; ylo = rq.yb; xhi = rq.xa; yhi = rq.ya;
		end
		// horizontal edge: slope is just dx, only one row gets touched
		if (yhi != ylo)
			slope = ((xhi - xlo) * (longint'(1) << FRAC)) / (yhi - ylo);
		else
			slope = (xhi - xlo) * (longint'(1) << FRAC);
		xf = xlo * (longint'(1) << FRAC);
		for (y = int'(ylo); y <= int'(yhi); y++) begin
			if (y < ROWS) begin
				if (xf < longint'(left_ext[y]) * (longint'(1) << FRAC))
					left_ext[y] = spf_pkg::LEFT_W'(pixel_of(xf));
				if (xf > longint'(right_ext[y]) * (longint'(1) << FRAC))
					right_ext[y] = pixel_of(xf);
			end
			xf += slope;
		end
	endfunction

	function automatic span_res_t apply_request(edge_req_t rq);
		span_res_t res;
		logic [spf_pkg::LEFT_W-1:0] l;
		logic [spf_pkg::PIX_W-1:0] r;
		res = '0;
		case (rq.kind)
			spf_pkg::REQ_CLEAR: begin
				for (int i = 0; i < ROWS; i++) begin
					left_ext[i]  = spf_pkg::EMPTY_LEFT;
					right_ext[i] = spf_pkg::EMPTY_RIGHT;
				end
				res.done = 1'b1;
			end
			spf_pkg::REQ_ADD: begin
				trace_edge(rq);
				res.done = 1'b1;
			end
			spf_pkg::REQ_SPAN: begin
				l = spf_pkg::EMPTY_LEFT;
				r = spf_pkg::EMPTY_RIGHT;
				if (rq.row < ROWS) begin
					l = left_ext[rq.row];
					r = right_ext[rq.row];
				end
				res.valid   = (l <= spf_pkg::LEFT_W'(r));
				res.left_x  = l;
				res.right_x = r;
				res.done    = 1'b1;
			end
			default: res = '0;   // reserved code: ignored, zero beat
		endcase
		return res;
	endfunction

	task automatic send_request(edge_req_t rq, logic fixed, span_res_t want);
		span_res_t pred;
		int gap, pick;
		pick = $urandom_range(0, 99);
		if (no_idle || pick < 50)
			gap = 0;
		else if (pick < 85)
			gap = $urandom_range(1, 3);
		else if (pick < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 80);
		if (gap > 0) begin
			start     = 1'b0;
			req_type  = 2'($urandom);
			edge_x_a  = spf_pkg::PIX_W'($urandom);
			edge_y_a  = spf_pkg::PIX_W'($urandom);
			edge_x_b  = spf_pkg::PIX_W'($urandom);
			edge_y_b  = spf_pkg::PIX_W'($urandom);
			query_row = spf_pkg::PIX_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		start     = 1'b1;
		req_type  = rq.kind;
		edge_x_a  = rq.xa;
		edge_y_a  = rq.ya;
		edge_x_b  = rq.xb;
		edge_y_b  = rq.yb;
		query_row = rq.row;
		do @(posedge clk); while (busy !== 1'b0);
		pred = apply_request(rq);
		pending_spans.push_back(fixed ? want : pred);
		n_items++;
		case (rq.kind)
			spf_pkg::REQ_CLEAR: n_clear++;
			spf_pkg::REQ_ADD:   n_add++;
			spf_pkg::REQ_SPAN:  begin
				n_span++;
				if (pred.valid)
					n_filled++;
			end
			default:   n_rsvd++;
		endcase
		@(negedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		span_res_t exp_r;
		if (arst_n && result_valid === 1'b1) begin
			if (pending_spans.size() == 0) begin
				$display("%0t: result beat with no request pending: expected none, got %b/%0d/%0d/%b",
					$time, span_valid, span_left, span_right_excl, req_done);
				fail_cnt++;
			end else begin
				exp_r = pending_spans.pop_front();
				check_field("span_valid", exp_r.valid, span_valid);
				check_field("span_left", exp_r.left_x, span_left);
				check_field("span_right_excl", exp_r.right_x, span_right_excl);
				check_field("req_done", exp_r.done, req_done);
				n_results++;
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT_CYC) begin
			$display("%0t: timeout after %0d cycles, %0d beats outstanding",
				$time, cyc, pending_spans.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		edge_req_t rq;
		int n, k, base, h, ymin, ymax, pick;
		int vx [6];
		int vy [6];
		fail_cnt  = 0;
		n_items   = 0; n_clear = 0; n_add = 0; n_span = 0;
		n_rsvd    = 0; n_filled = 0; n_results = 0;
		no_idle   = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req_type  = '0;
		edge_x_a  = '0;
		edge_y_a  = '0;
		edge_x_b  = '0;
		edge_y_b  = '0;
		query_row = '0;
		for (int i = 0; i < ROWS; i++) begin
			left_ext[i]  = spf_pkg::EMPTY_LEFT;
			right_ext[i] = spf_pkg::EMPTY_RIGHT;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_request(dir_tab[i].rq, dir_tab[i].fixed, dir_tab[i].want);

		while (n_items < N_DIR + RAND_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				rq.kind = spf_pkg::REQ_CLEAR;
				rq.xa   = spf_pkg::PIX_W'($urandom);
				rq.ya   = spf_pkg::PIX_W'($urandom);
				rq.xb   = spf_pkg::PIX_W'($urandom);
				rq.yb   = spf_pkg::PIX_W'($urandom);
				rq.row  = spf_pkg::PIX_W'($urandom);
				send_request(rq, 1'b0, '0);
			end else if (pick < 25) begin
				// loose noise, any code including the reserved one
				repeat ($urandom_range(1, 4)) begin
					rq.kind = 2'($urandom);
					rq.xa   = spf_pkg::PIX_W'($urandom);
					rq.ya   = spf_pkg::PIX_W'($urandom);
					rq.xb   = spf_pkg::PIX_W'($urandom);
					rq.yb   = spf_pkg::PIX_W'($urandom);
					rq.row  = spf_pkg::PIX_W'($urandom);
					send_request(rq, 1'b0, '0);
				end
			end else begin
				// closed polygon, mostly short in y to keep edge walks cheap
				n    = $urandom_range(3, 6);
				base = $urandom_range(0, 511);
				h    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
				                                    : $urandom_range(0, 40);
				ymin = 511;
				ymax = 0;
				for (k = 0; k < n; k++) begin
					vx[k] = $urandom_range(0, 511);
					vy[k] = base + $urandom_range(0, h);
					if (vy[k] > 511)
						vy[k] = 511;
					if (vy[k] < ymin)
						ymin = vy[k];
					if (vy[k] > ymax)
						ymax = vy[k];
				end
				for (k = 0; k < n; k++) begin
					rq.kind = spf_pkg::REQ_ADD;
					rq.xa   = spf_pkg::PIX_W'(vx[k]);
					rq.ya   = spf_pkg::PIX_W'(vy[k]);
					rq.xb   = spf_pkg::PIX_W'(vx[(k + 1) % n]);
					rq.yb   = spf_pkg::PIX_W'(vy[(k + 1) % n]);
					rq.row  = spf_pkg::PIX_W'($urandom);
					send_request(rq, 1'b0, '0);
				end
				repeat ($urandom_range(2, 6)) begin
					rq.kind = spf_pkg::REQ_SPAN;
					rq.xa   = spf_pkg::PIX_W'($urandom);
					rq.ya   = spf_pkg::PIX_W'($urandom);
					rq.xb   = spf_pkg::PIX_W'($urandom);
					rq.yb   = spf_pkg::PIX_W'($urandom);
					rq.row  = ($urandom_range(0, 4) != 0)
					          ? spf_pkg::PIX_W'($urandom_range(ymin, ymax))
					          : spf_pkg::PIX_W'($urandom);
					send_request(rq, 1'b0, '0);
				end
			end
		end

		start = 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Covered %0d requests: %0d clears, %0d edges, %0d span reads (%0d filled), %0d reserved",
			n_items, n_clear, n_add, n_span, n_filled, n_rsvd);
		$display("Checked %0d result beats, %0d field mismatches", n_results, fail_cnt);
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/spf_pkg.sv
design/spf_div.sv
design/spf_dp.sv
design/spf_ctrl.sv
design/scanline_polygon_span_fill.sv
tb/sv/scanline_polygon_span_fill_tb.sv
